@@ design/etok_pkg.sv @@
// ----------------------------------------------------------------------------
// etok_pkg - shared types and constants of the expression tokenizer
// Token codes, scan modes, character constants, the token record and the
// character classification helpers used by the scan core.
// ----------------------------------------------------------------------------
package etok_pkg;

  // Scan mode of the tokenizer
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ZERO   = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_IDENT  = 2'd3
  } scan_mode_t;

  // Token kinds as seen on the result channel
  typedef enum logic [3:0] {
    TOK_NUMBER    = 4'd0,
    TOK_IDENT     = 4'd1,
    TOK_LPAREN    = 4'd2,
    TOK_RPAREN    = 4'd3,
    TOK_SEMICOLON = 4'd4,
    TOK_PLUS      = 4'd5,
    TOK_MINUS     = 4'd6,
    TOK_SLASH     = 4'd7,
    TOK_STAR      = 4'd8,
    TOK_PERCENT   = 4'd9,
    TOK_CARET     = 4'd10,
    TOK_EQUALS    = 4'd11,
    TOK_ERROR     = 4'd12,
    TOK_EOF       = 4'd13
  } tok_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIGIT    = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_code_t;

  // Numeric bases
  localparam logic [4:0] BASE_2  = 5'd2;
  localparam logic [4:0] BASE_8  = 5'd8;
  localparam logic [4:0] BASE_10 = 5'd10;
  localparam logic [4:0] BASE_16 = 5'd16;

  // Character codes
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_ONE        = 8'h31;
  localparam logic [7:0] CHAR_NINE       = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
  localparam logic [7:0] CHAR_A          = 8'h61;
  localparam logic [7:0] CHAR_B          = 8'h62;
  localparam logic [7:0] CHAR_F          = 8'h66;
  localparam logic [7:0] CHAR_X          = 8'h78;
  localparam logic [7:0] CHAR_Z          = 8'h7A;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
  localparam logic [7:0] CASE_OFFSET     = 8'd32;

  localparam logic [15:0] LINE_MAX   = 16'hFFFF;
  localparam logic [15:0] LINE_FIRST = 16'd1;

  // Result queue depth (power of two)
  localparam int QUEUE_DEPTH = 8;

  // One result item
  typedef struct packed {
    tok_kind_t   kind;
    logic [63:0] number_value;
    logic [12:0] ident_start;
    logic [12:0] ident_length;
    err_code_t   error_code;
    logic [15:0] line_number;
    logic [12:0] column;
    logic        last_result;
  } token_t;

  // Results of one scan step, handed from the core to the queue
  typedef struct packed {
    logic [1:0]       count;
    token_t [1:0]     tok;
  } push_t;

  function automatic logic [7:0] lower_case(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) r = c + CASE_OFFSET;
    return r;
  endfunction

  // {valid, digit}: 0-9 and a-f
  function automatic logic [4:0] digit_of(logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r = {1'b1, c[3:0]};
    end else if (c >= CHAR_A && c <= CHAR_F) begin
      r = {1'b1, 4'(c - CHAR_A + 8'd10)};
    end
    return r;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= CHAR_A && c <= CHAR_Z) || c == CHAR_UNDERSCORE;
  endfunction

  function automatic logic is_word_char(logic [7:0] c);
    return is_letter(c) || (c >= CHAR_ZERO && c <= CHAR_NINE);
  endfunction

  // Single-character tokens; TOK_NUMBER means "not an operator"
  function automatic tok_kind_t op_kind(logic [7:0] c);
    tok_kind_t k;
    unique case (c)
      "(":     k = TOK_LPAREN;
      ")":     k = TOK_RPAREN;
      ";":     k = TOK_SEMICOLON;
      "+":     k = TOK_PLUS;
      "-":     k = TOK_MINUS;
      "/":     k = TOK_SLASH;
      "*":     k = TOK_STAR;
      "%":     k = TOK_PERCENT;
      "^":     k = TOK_CARET;
      "=":     k = TOK_EQUALS;
      default: k = TOK_NUMBER;
    endcase
    return k;
  endfunction

endpackage

@@ design/etok_if.sv @@
// ----------------------------------------------------------------------------
// etok_if - stream channels of the expression tokenizer
// Character channel and token channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface etok_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface etok_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [63:0] number_value;
  logic [12:0] ident_start;
  logic [12:0] ident_length;
  logic [1:0]  error_code;
  logic [15:0] line_number;
  logic [12:0] column;
  logic        last_result;

  modport source (
    output valid, output token_kind, output number_value, output ident_start,
    output ident_length, output error_code, output line_number, output column,
    output last_result, input ready
  );
  modport sink (
    input valid, input token_kind, input number_value, input ident_start,
    input ident_length, input error_code, input line_number, input column,
    input last_result, output ready
  );
endinterface

@@ design/etok_core.sv @@
// ----------------------------------------------------------------------------
// etok_core - input register, scan state and single-pass token logic
// Registers each accepted character or end-of-line item, then in the next cycle
// updates the scan state and produces up to two tokens for the result queue.
// ----------------------------------------------------------------------------
module etok_core #(
  parameter int MAX_LINE_LENGTH = 4096,
  parameter int VALUE_WIDTH     = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             req_type,
  input  logic [7:0]       char_code,
  output logic             busy,
  output etok_pkg::push_t  push
);

  localparam int CW = $clog2(MAX_LINE_LENGTH + 1);
  localparam int VW = VALUE_WIDTH;
  localparam int PW = VALUE_WIDTH + 5;
  localparam logic [CW-1:0] COL_LIMIT = CW'(MAX_LINE_LENGTH);

  // Input register
  logic       stage_valid;
  logic       stage_eol;
  logic [7:0] stage_char;

  // Scan state
  etok_pkg::scan_mode_t mode, mode_next;
  logic [4:0]    base, base_next;
  logic [VW-1:0] acc, acc_next;
  logic [CW-1:0] tstart, tstart_next;
  logic [CW-1:0] col, col_next;
  logic [15:0]   lines, lines_next;

  // Step logic
  logic [7:0]       c;
  logic [4:0]       dig;
  logic [4:0]       eff_base;
  logic [PW-1:0]    acc_wide;
  logic [PW-1:0]    scaled;
  logic [PW-1:0]    prod;
  logic             overflow;
  logic [CW-1:0]    col_adv;
  logic [CW-1:0]    ident_len;
  logic             rescan;
  logic             pre_v, post_v;
  etok_pkg::token_t pre_tok, post_tok;
  etok_pkg::tok_kind_t op;

  function automatic etok_pkg::token_t make_tok(
    etok_pkg::tok_kind_t kind,
    logic [VW-1:0]       value,
    logic [CW-1:0]       istart,
    logic [CW-1:0]       ilen,
    etok_pkg::err_code_t err,
    logic [15:0]         line,
    logic [CW-1:0]       column
  );
    etok_pkg::token_t t;
    logic [VW+63:0]   vx;
    logic [CW+12:0]   sx;
    logic [CW+12:0]   lx;
    logic [CW+12:0]   cx;
    vx = {64'b0, value};
    sx = {13'b0, istart};
    lx = {13'b0, ilen};
    cx = {13'b0, column};
    t.kind         = kind;
    t.number_value = vx[63:0];
    t.ident_start  = sx[12:0];
    t.ident_length = lx[12:0];
    t.error_code   = err;
    t.line_number  = line;
    t.column       = cx[12:0];
    t.last_result  = 1'b0;
    return t;
  endfunction

  // Capture each transfer into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= accept;
    end
    if (accept) begin
      stage_eol  <= req_type;
      stage_char <= char_code;
    end
  end

  assign busy = stage_valid;

  // Character classes and the next accumulator value
  assign c         = etok_pkg::lower_case(stage_char);
  assign dig       = etok_pkg::digit_of(c);
  assign op        = etok_pkg::op_kind(c);
  assign eff_base  = (mode == etok_pkg::MODE_ZERO) ? etok_pkg::BASE_8 : base;
  assign acc_wide  = PW'(acc);
  assign col_adv   = (col < COL_LIMIT) ? col + CW'(1) : col;
  assign ident_len = col - tstart;

  always_comb begin
    unique case (eff_base)
      etok_pkg::BASE_2:  scaled = acc_wide << 1;
      etok_pkg::BASE_8:  scaled = acc_wide << 3;
      etok_pkg::BASE_16: scaled = acc_wide << 4;
      default:           scaled = (acc_wide << 3) + (acc_wide << 1);
    endcase
  end

  // acc * base + digit beyond VALUE_WIDTH bits means overflow
  assign prod     = scaled + PW'(dig[3:0]);
  assign overflow = |prod[PW-1:VW];

  // Scan one character or end of line
  always_comb begin
    mode_next   = mode;
    base_next   = base;
    acc_next    = acc;
    tstart_next = tstart;
    col_next    = col;
    lines_next  = lines;
    rescan      = 1'b0;
    pre_v       = 1'b0;
    post_v      = 1'b0;
    pre_tok     = '0;
    post_tok    = '0;

    if (stage_eol) begin
      // Flush the pending token, then end of file
      if (mode == etok_pkg::MODE_ZERO || mode == etok_pkg::MODE_NUMBER) begin
        pre_v   = 1'b1;
        pre_tok = make_tok(etok_pkg::TOK_NUMBER, acc, '0, '0, etok_pkg::ERR_NONE,
                           lines, col);
      end else if (mode == etok_pkg::MODE_IDENT) begin
        pre_v   = 1'b1;
        pre_tok = make_tok(etok_pkg::TOK_IDENT, '0, tstart, ident_len,
                           etok_pkg::ERR_NONE, lines, col);
      end
      post_v    = 1'b1;
      post_tok  = make_tok(etok_pkg::TOK_EOF, '0, '0, '0, etok_pkg::ERR_NONE,
                           lines, col);
      mode_next = etok_pkg::MODE_IDLE;
      base_next = etok_pkg::BASE_10;
      acc_next  = '0;
      col_next  = '0;
    end else begin
      unique case (mode)
        etok_pkg::MODE_ZERO, etok_pkg::MODE_NUMBER: begin
          if (mode == etok_pkg::MODE_ZERO && (c == etok_pkg::CHAR_X ||
                                              c == etok_pkg::CHAR_B)) begin
            mode_next = etok_pkg::MODE_NUMBER;
            base_next = (c == etok_pkg::CHAR_X) ? etok_pkg::BASE_16 : etok_pkg::BASE_2;
            col_next  = col_adv;
          end else if (!dig[4]) begin
            pre_v   = 1'b1;
            pre_tok = make_tok(etok_pkg::TOK_NUMBER, acc, '0, '0, etok_pkg::ERR_NONE,
                               lines, col);
            rescan  = 1'b1;
          end else if ({1'b0, dig[3:0]} >= eff_base) begin
            pre_v   = 1'b1;
            pre_tok = make_tok(etok_pkg::TOK_ERROR, '0, '0, '0, etok_pkg::ERR_DIGIT,
                               lines, col);
            rescan  = 1'b1;
          end else if (overflow) begin
            pre_v   = 1'b1;
            pre_tok = make_tok(etok_pkg::TOK_ERROR, '0, '0, '0,
                               etok_pkg::ERR_OVERFLOW, lines, col);
            rescan  = 1'b1;
          end else begin
            mode_next = etok_pkg::MODE_NUMBER;
            base_next = eff_base;
            acc_next  = prod[VW-1:0];
            col_next  = col_adv;
          end
        end
        etok_pkg::MODE_IDENT: begin
          if (etok_pkg::is_word_char(c)) begin
            col_next = col_adv;
          end else begin
            pre_v   = 1'b1;
            pre_tok = make_tok(etok_pkg::TOK_IDENT, '0, tstart, ident_len,
                               etok_pkg::ERR_NONE, lines, col);
            rescan  = 1'b1;
          end
        end
        etok_pkg::MODE_IDLE: begin
          rescan = 1'b1;
        end
      endcase

      // Start a new token from idle, also after a token ends or breaks
      if (rescan) begin
        mode_next = etok_pkg::MODE_IDLE;
        base_next = etok_pkg::BASE_10;
        acc_next  = '0;
        col_next  = col_adv;
        if (c == etok_pkg::CHAR_ZERO) begin
          mode_next   = etok_pkg::MODE_ZERO;
          tstart_next = col;
        end else if (c >= etok_pkg::CHAR_ONE && c <= etok_pkg::CHAR_NINE) begin
          mode_next   = etok_pkg::MODE_NUMBER;
          acc_next    = VW'(c[3:0]);
          tstart_next = col;
        end else if (etok_pkg::is_letter(c)) begin
          mode_next   = etok_pkg::MODE_IDENT;
          tstart_next = col;
        end else if (op != etok_pkg::TOK_NUMBER) begin
          post_v   = 1'b1;
          post_tok = make_tok(op, '0, '0, '0, etok_pkg::ERR_NONE, lines, col_adv);
        end else if (c == etok_pkg::CHAR_NEWLINE && lines != etok_pkg::LINE_MAX) begin
          lines_next = lines + 16'd1;
        end
      end
    end
  end

  // Pack the results in order and mark the last one
  always_comb begin
    push = '0;
    if (stage_valid) begin
      push.count = {1'b0, pre_v} + {1'b0, post_v};
      if (pre_v) begin
        push.tok[0] = pre_tok;
        push.tok[1] = post_tok;
        push.tok[0].last_result = !post_v;
        push.tok[1].last_result = 1'b1;
      end else begin
        push.tok[0] = post_tok;
        push.tok[0].last_result = 1'b1;
      end
    end
  end

  // Update the scan state once per registered item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= etok_pkg::MODE_IDLE;
      base   <= etok_pkg::BASE_10;
      acc    <= '0;
      tstart <= '0;
      col    <= '0;
      lines  <= etok_pkg::LINE_FIRST;
    end else if (stage_valid) begin
      mode   <= mode_next;
      base   <= base_next;
      acc    <= acc_next;
      tstart <= tstart_next;
      col    <= col_next;
      lines  <= lines_next;
    end
  end

endmodule

@@ design/etok_queue.sv @@
// ----------------------------------------------------------------------------
// etok_queue - result queue of the expression tokenizer
// Takes up to two tokens per cycle, hands out one per transfer in order.
// ----------------------------------------------------------------------------
module etok_queue (
  input  logic              clk,
  input  logic              rst,
  input  etok_pkg::push_t   push,
  input  logic              out_ready,
  output logic              out_valid,
  output etok_pkg::token_t  head_tok,
  output logic [$clog2(etok_pkg::QUEUE_DEPTH+1)-1:0] level
);

  localparam int IW = $clog2(etok_pkg::QUEUE_DEPTH);
  localparam int LW = $clog2(etok_pkg::QUEUE_DEPTH + 1);

  etok_pkg::token_t entries [etok_pkg::QUEUE_DEPTH];
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] tail, tail_next;
  logic [LW-1:0] count, count_next;
  logic          pop;

  assign out_valid = (count != '0);
  assign head_tok  = entries[head];
  assign level     = count;
  assign pop       = out_valid && out_ready;

  // Advance pointers and fill level
  always_comb begin
    head_next  = pop ? head + IW'(1) : head;
    tail_next  = tail + IW'(push.count);
    count_next = count + LW'(push.count) - LW'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Write the new tokens behind the tail
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[tail] <= push.tok[0];
    end
    if (push.count == 2'd2) begin
      entries[tail + IW'(1)] <= push.tok[1];
    end
  end

endmodule

@@ design/expression_tokenizer.sv @@
// ----------------------------------------------------------------------------
// expression_tokenizer - character stream to expression tokens
// Scans one character or end-of-line marker per transfer and emits number,
// identifier, operator, error and end-of-file tokens.
// ----------------------------------------------------------------------------
// Usage:
//   items  : character channel; req_type 1 marks end of line, else char_code
//            holds the byte. An item transfers when valid and ready are high.
//   tokens : token channel; each token carries kind, value, identifier
//            position, error code, line, column and last_result, which is set
//            on the last token caused by an item.
//   Path:    the first token of an item passes the input register, the scan
//            step and the result queue before it can transfer.
//   Throughput: one item per cycle while items.ready is high; an item gives
//            zero, one or two tokens and the token channel moves one per cycle,
//            so items that end a token and start an operator (two tokens) slow
//            it down. The eight-entry result queue sets how far the sides slip.
//   Stall: while the receiver holds ready low, tokens wait in the queue and
//            items are still taken while at least two entries stay free for
//            each item in flight; then items.ready drops.
//   Reset: rst (synchronous) empties the queue, drops the item in flight and
//            returns the scanner to idle, base ten, column 0, line 1.
// ----------------------------------------------------------------------------
module expression_tokenizer #(
  parameter int MAX_LINE_LENGTH = 4096,
  parameter int VALUE_WIDTH     = 64
) (
  input  logic       clk,
  input  logic       rst,
  etok_in_if.sink    items,
  etok_out_if.source tokens
);

  localparam int LW = $clog2(etok_pkg::QUEUE_DEPTH + 1);

  logic             accept;
  logic             busy;
  etok_pkg::push_t  push;
  etok_pkg::token_t head_tok;
  logic [LW-1:0]    level;
  logic [LW-1:0]    free_slots;
  logic [LW-1:0]    need_slots;

  // Keep room for the item in flight and the one being taken
  assign free_slots  = LW'(etok_pkg::QUEUE_DEPTH) - level;
  assign need_slots  = busy ? LW'(4) : LW'(2);
  assign items.ready = (free_slots >= need_slots);
  assign accept      = items.valid && items.ready;

  etok_core #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
    .VALUE_WIDTH     (VALUE_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (items.req_type),
    .char_code (items.char_code),
    .busy      (busy),
    .push      (push)
  );

  etok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_ready (tokens.ready),
    .out_valid (tokens.valid),
    .head_tok  (head_tok),
    .level     (level)
  );

  // Drive the token channel from the queue head
  assign tokens.token_kind   = head_tok.kind;
  assign tokens.number_value = head_tok.number_value;
  assign tokens.ident_start  = head_tok.ident_start;
  assign tokens.ident_length = head_tok.ident_length;
  assign tokens.error_code   = head_tok.error_code;
  assign tokens.line_number  = head_tok.line_number;
  assign tokens.column       = head_tok.column;
  assign tokens.last_result  = head_tok.last_result;

endmodule

@@ design/etok_checker.sv @@
// ----------------------------------------------------------------------------
// etok_checker - port-level checks of the expression tokenizer
// Watches the token channel for reset behavior, stall hold and token rules.
// ----------------------------------------------------------------------------
module etok_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  token_kind,
  input logic [63:0] number_value,
  input logic [15:0] line_number,
  input logic [12:0] column,
  input logic        last_result
);

  // No token right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("token valid right after reset");

  // Hold a stalled token
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
      $stable(number_value) && $stable(column) && $stable(last_result))
    else $error("stalled token changed");

  // End of file always closes the tokens of its item
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == etok_pkg::TOK_EOF |-> last_result)
    else $error("end-of-file token without last_result");

  // Line count starts at one and never wraps
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_number != 16'd0)
    else $error("line number zero");

  // Only number tokens carry a value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != etok_pkg::TOK_NUMBER |-> number_value == 64'd0)
    else $error("value on a non-number token");

endmodule

bind expression_tokenizer etok_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (tokens.valid),
  .out_ready    (tokens.ready),
  .token_kind   (tokens.token_kind),
  .number_value (tokens.number_value),
  .line_number  (tokens.line_number),
  .column       (tokens.column),
  .last_result  (tokens.last_result)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - expression tokenizer testbench
// Sends character and end-of-line items into the tokenizer, predicts the
// token stream from its own scanner model and checks every token field by
// field. Runs short directed strings, then random token-shaped text under
// several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;

  localparam int          CYCLE_LIMIT = 100_000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          RANDOM_ITEMS = 240;
  localparam int          COLUMN_LIMIT = 4096;
  localparam logic [63:0] VALUE_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [7:0]  CHAR_SPACE = 8'h20;
  localparam logic [7:0]  CHAR_TAB = 8'h09;
  localparam logic [7:0]  CHAR_CR = 8'h0D;
  localparam string       HEX_DIGITS = "0123456789abcdef";
  localparam string       WORD_CHARS = "abcdefghijklmnopqrstuvwxyz0123456789_";
  localparam string       OPERATORS = "()+;-/*%^=";

  typedef struct packed {
    logic       eol;
    logic [7:0] code;
  } char_item_t;

  logic clk;
  logic rst;

  etok_in_if  items();
  etok_out_if tokens();

  expression_tokenizer u_dut (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .tokens (tokens)
  );

  char_item_t         char_queue[$];
  etok_pkg::token_t   expected_tokens[$];
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 n_errors;
  int                 cycle_count;

  // Scanner copy used for prediction
  etok_pkg::scan_mode_t mode_q;
  logic [4:0]  base_q;
  logic [63:0] acc_q;
  int unsigned start_q;
  int unsigned col_q;
  int unsigned line_q;

  // Generate the clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int digit_value(logic [7:0] c);
    if (c >= etok_pkg::CHAR_ZERO && c <= etok_pkg::CHAR_NINE)
      return int'(c - etok_pkg::CHAR_ZERO);
    if (c >= etok_pkg::CHAR_A && c <= etok_pkg::CHAR_F)
      return int'(c - etok_pkg::CHAR_A) + 10;
    return -1;
  endfunction

  function automatic logic word_char(logic [7:0] c);
    return (c >= etok_pkg::CHAR_A && c <= etok_pkg::CHAR_Z) ||
           (c >= etok_pkg::CHAR_ZERO && c <= etok_pkg::CHAR_NINE) ||
           c == etok_pkg::CHAR_UNDERSCORE;
  endfunction

  function automatic etok_pkg::tok_kind_t operator_token(logic [7:0] c);
    case (c)
      "(":     return etok_pkg::TOK_LPAREN;
      ")":     return etok_pkg::TOK_RPAREN;
      ";":     return etok_pkg::TOK_SEMICOLON;
      "+":     return etok_pkg::TOK_PLUS;
      "-":     return etok_pkg::TOK_MINUS;
      "/":     return etok_pkg::TOK_SLASH;
      "*":     return etok_pkg::TOK_STAR;
      "%":     return etok_pkg::TOK_PERCENT;
      "^":     return etok_pkg::TOK_CARET;
      "=":     return etok_pkg::TOK_EQUALS;
      default: return etok_pkg::TOK_NUMBER;
    endcase
  endfunction

  function automatic string format_token(etok_pkg::token_t t);
    return $sformatf("kind=%0d value=%h start=%0d len=%0d err=%0d line=%0d col=%0d last=%0b",
                     t.kind, t.number_value, t.ident_start, t.ident_length,
                     t.error_code, t.line_number, t.column, t.last_result);
  endfunction

  task automatic predict_token(etok_pkg::tok_kind_t kind, logic [63:0] value,
                               int unsigned istart, int unsigned ilen,
                               etok_pkg::err_code_t err);
    etok_pkg::token_t t;
    t.kind         = kind;
    t.number_value = value;
    t.ident_start  = 13'(istart);
    t.ident_length = 13'(ilen);
    t.error_code   = err;
    t.line_number  = 16'(line_q);
    t.column       = 13'(col_q);
    t.last_result  = 1'b0;
    expected_tokens.insert(expected_tokens.size(), t);
  endtask

  task automatic advance_column();
    if (col_q < COLUMN_LIMIT) col_q++;
  endtask

  task automatic back_to_idle();
    mode_q = etok_pkg::MODE_IDLE;
    base_q = etok_pkg::BASE_10;
    acc_q  = '0;
  endtask

  // Predict the tokens caused by one accepted item
  task automatic scan_item(logic eol, logic [7:0] code);
    logic [7:0]       c;
    int               d;
    int               n_before;
    logic             consumed;
    etok_pkg::token_t last_tok;
    n_before = expected_tokens.size();
    consumed = 1'b0;
    if (eol) begin
      // flush the pending token, then end the line
      if (mode_q == etok_pkg::MODE_ZERO || mode_q == etok_pkg::MODE_NUMBER) begin
        predict_token(etok_pkg::TOK_NUMBER, acc_q, 0, 0, etok_pkg::ERR_NONE);
      end else if (mode_q == etok_pkg::MODE_IDENT) begin
        predict_token(etok_pkg::TOK_IDENT, '0, start_q, col_q - start_q,
                      etok_pkg::ERR_NONE);
      end
      predict_token(etok_pkg::TOK_EOF, '0, 0, 0, etok_pkg::ERR_NONE);
      back_to_idle();
      col_q = 0;
    end else begin
      c = code;
      if (c >= etok_pkg::CHAR_UPPER_A && c <= etok_pkg::CHAR_UPPER_Z)
        c = c + etok_pkg::CASE_OFFSET;
      // after a leading zero, pick the base
      if (mode_q == etok_pkg::MODE_ZERO) begin
        mode_q = etok_pkg::MODE_NUMBER;
        if (c == etok_pkg::CHAR_X || c == etok_pkg::CHAR_B) begin
          base_q = (c == etok_pkg::CHAR_X) ? etok_pkg::BASE_16 : etok_pkg::BASE_2;
          advance_column();
          consumed = 1'b1;
        end else begin
          base_q = etok_pkg::BASE_8;
        end
      end
      // continue or end a number
      if (!consumed && mode_q == etok_pkg::MODE_NUMBER) begin
        d = digit_value(c);
        if (d < 0) begin
          predict_token(etok_pkg::TOK_NUMBER, acc_q, 0, 0, etok_pkg::ERR_NONE);
          back_to_idle();
        end else if (d >= int'(base_q)) begin
          predict_token(etok_pkg::TOK_ERROR, '0, 0, 0, etok_pkg::ERR_DIGIT);
          back_to_idle();
        end else if (acc_q > (VALUE_MAX - 64'(d)) / 64'(base_q)) begin
          predict_token(etok_pkg::TOK_ERROR, '0, 0, 0, etok_pkg::ERR_OVERFLOW);
          back_to_idle();
        end else begin
          acc_q = acc_q * 64'(base_q) + 64'(d);
          advance_column();
          consumed = 1'b1;
        end
      end else if (!consumed && mode_q == etok_pkg::MODE_IDENT) begin
        // continue or end an identifier
        if (word_char(c)) begin
          advance_column();
          consumed = 1'b1;
        end else begin
          predict_token(etok_pkg::TOK_IDENT, '0, start_q, col_q - start_q,
                        etok_pkg::ERR_NONE);
          back_to_idle();
        end
      end
      // scan the character from idle
      if (!consumed) begin
        if (c == etok_pkg::CHAR_ZERO) begin
          mode_q  = etok_pkg::MODE_ZERO;
          acc_q   = '0;
          start_q = col_q;
          advance_column();
        end else if (c >= etok_pkg::CHAR_ONE && c <= etok_pkg::CHAR_NINE) begin
          mode_q  = etok_pkg::MODE_NUMBER;
          base_q  = etok_pkg::BASE_10;
          acc_q   = 64'(c - etok_pkg::CHAR_ZERO);
          start_q = col_q;
          advance_column();
        end else if ((c >= etok_pkg::CHAR_A && c <= etok_pkg::CHAR_Z) ||
                     c == etok_pkg::CHAR_UNDERSCORE) begin
          mode_q  = etok_pkg::MODE_IDENT;
          start_q = col_q;
          advance_column();
        end else if (operator_token(c) != etok_pkg::TOK_NUMBER) begin
          advance_column();
          predict_token(operator_token(c), '0, 0, 0, etok_pkg::ERR_NONE);
        end else begin
          if (c == etok_pkg::CHAR_NEWLINE && line_q < etok_pkg::LINE_MAX) line_q++;
          advance_column();
        end
      end
    end
    // flag the last token of this item
    if (expected_tokens.size() > n_before) begin
      last_tok = expected_tokens.pop_back();
      last_tok.last_result = 1'b1;
      expected_tokens.insert(expected_tokens.size(), last_tok);
    end
  endtask

  // Drive the character channel; predict on each transfer
  always @(posedge clk) begin : char_driver
    char_item_t next_item;
    if (rst) begin
      items.valid     <= 1'b0;
      items.req_type  <= 1'b0;
      items.char_code <= '0;
      back_to_idle();
      start_q = 0;
      col_q   = 0;
      line_q  = 1;
    end else begin
      if (items.valid && items.ready) begin
        scan_item(items.req_type, items.char_code);
      end
      if (!items.valid || items.ready) begin
        if (char_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = char_queue.pop_front();
          items.valid     <= 1'b1;
          items.req_type  <= next_item.eol;
          items.char_code <= next_item.code;
        end else begin
          items.valid <= 1'b0;
        end
      end
    end
  end

  // Check each token transfer against the oldest prediction
  always @(posedge clk) begin : token_monitor
    etok_pkg::token_t got;
    etok_pkg::token_t want;
    if (rst) begin
      tokens.ready <= 1'b0;
    end else begin
      if (tokens.valid && tokens.ready) begin
        got.kind         = etok_pkg::tok_kind_t'(tokens.token_kind);
        got.number_value = tokens.number_value;
        got.ident_start  = tokens.ident_start;
        got.ident_length = tokens.ident_length;
        got.error_code   = etok_pkg::err_code_t'(tokens.error_code);
        got.line_number  = tokens.line_number;
        got.column       = tokens.column;
        got.last_result  = tokens.last_result;
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token %s", $time, format_token(got));
          n_errors++;
        end else begin
          want = expected_tokens.pop_front();
          if (got !== want) begin
            $display("%0t: token mismatch", $time);
            $display("  expected %s", format_token(want));
            $display("  actual   %s", format_token(got));
            n_errors++;
          end
        end
      end
      tokens.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic add_char(logic [7:0] c);
    char_queue.insert(char_queue.size(), '{eol: 1'b0, code: c});
  endtask

  task automatic add_eol();
    char_queue.insert(char_queue.size(), '{eol: 1'b1, code: 8'($urandom_range(255))});
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
  endtask

  function automatic logic [7:0] any_case(logic [7:0] c);
    if (c >= etok_pkg::CHAR_A && c <= etok_pkg::CHAR_Z && $urandom_range(1) == 1)
      return c - etok_pkg::CASE_OFFSET;
    return c;
  endfunction

  // Append one random token-shaped fragment; n counts the items that matter
  task automatic add_fragment(output int n);
    int sel;
    int len;
    logic [7:0] c;
    sel = $urandom_range(99);
    n = char_queue.size();
    if (sel < 25) begin
      // decimal, now and then at the overflow boundary or broken by a letter
      if ($urandom_range(9) == 0) begin
        add_str($urandom_range(1) ? "18446744073709551615" : "18446744073709551616");
      end else begin
        add_char(8'(etok_pkg::CHAR_ONE + $urandom_range(8)));
        len = $urandom_range(21);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(29) == 0) add_char(any_case(HEX_DIGITS[$urandom_range(15, 10)]));
          else add_char(HEX_DIGITS[$urandom_range(9)]);
        end
      end
    end else if (sel < 40) begin
      // hex, sometimes all f to reach the top value
      add_char(etok_pkg::CHAR_ZERO);
      add_char(any_case(etok_pkg::CHAR_X));
      len = $urandom_range(17);
      for (int i = 0; i < len; i++) begin
        if (sel < 28) add_char(any_case(etok_pkg::CHAR_F));
        else add_char(any_case(HEX_DIGITS[$urandom_range(15)]));
      end
    end else if (sel < 50) begin
      // binary, rarely a digit that is too large
      add_char(etok_pkg::CHAR_ZERO);
      add_char(any_case(etok_pkg::CHAR_B));
      len = $urandom_range(66);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(39) == 0) add_char(8'(etok_pkg::CHAR_ZERO + $urandom_range(9, 2)));
        else add_char(8'(etok_pkg::CHAR_ZERO + $urandom_range(1)));
      end
    end else if (sel < 58) begin
      // octal, rarely an 8 or a 9
      add_char(etok_pkg::CHAR_ZERO);
      len = $urandom_range(23);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(29) == 0) add_char(8'(etok_pkg::CHAR_ZERO + $urandom_range(9, 8)));
        else add_char(8'(etok_pkg::CHAR_ZERO + $urandom_range(7)));
      end
    end else if (sel < 75) begin
      // identifier
      c = WORD_CHARS[$urandom_range(26)];
      if (c < etok_pkg::CHAR_A) c = etok_pkg::CHAR_UNDERSCORE;
      add_char(any_case(c));
      len = $urandom_range(12);
      for (int i = 0; i < len; i++) add_char(any_case(WORD_CHARS[$urandom_range(36)]));
    end else if (sel < 88) begin
      add_char(OPERATORS[$urandom_range(9)]);
    end else if (sel < 94) begin
      case ($urandom_range(3))
        0: add_char(CHAR_SPACE);
        1: add_char(CHAR_TAB);
        2: add_char(CHAR_CR);
        default: add_char(etok_pkg::CHAR_NEWLINE);
      endcase
      n = char_queue.size();
    end else if (sel < 97) begin
      add_eol();
    end else begin
      add_char(8'($urandom_range(255)));
      n = char_queue.size();
    end
    n = char_queue.size() - n;
  endtask

  task automatic add_random(int target);
    int made;
    int n;
    made = 0;
    while (made < target) begin
      add_fragment(n);
      made += n;
    end
    add_eol();
  endtask

  task automatic wait_sent();
    while (char_queue.size() != 0 || items.valid) @(posedge clk);
  endtask

  // Reset, run the phases, then drain and report
  initial begin
    rst            <= 1'b1;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // operators, prefix letter, case folding, unknown bytes, lone prefixes
    add_str("(+-*/%^=);");
    add_str("0b2");
    add_str("Zf");
    add_char(8'h00);
    add_char(8'hFF);
    add_char(etok_pkg::CHAR_NEWLINE);
    add_str("0x");
    add_eol();
    add_str("0");
    add_eol();
    wait_sent();

    // random text under each idle and stall mix
    add_random(RANDOM_ITEMS);
    wait_sent();
    send_idle_pct = 71;
    add_random(RANDOM_ITEMS);
    wait_sent();
    send_idle_pct  = 0;
    recv_stall_pct = 71;
    add_random(RANDOM_ITEMS);
    wait_sent();
    send_idle_pct  = 37;
    recv_stall_pct = 37;
    add_random(RANDOM_ITEMS);
    wait_sent();

    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
